// ===== sv/cobs_dfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cobs deframer package
// shared types and constants for the leading-delimiter cobs deframer
// ----------------------------------------------------------------------------
package cobs_dfr_pkg;

   localparam int HDR_BYTES   = 1 + 2;
   localparam int MAX_RESULTS = 3;

   localparam logic [7:0] DELIM_BYTE = 8'h00;
   localparam logic [7:0] FULL_CODE  = 8'hFF;

   typedef enum logic [1:0] {
      KIND_PAYLOAD   = 2'd0,
      KIND_DONE      = 2'd1,
      KIND_BAD_MAGIC = 2'd2,
      KIND_TRUNCATED = 2'd3
   } kind_type;

   // decoder state carried from byte to byte
   typedef struct packed {
      logic [7:0]  group_left;
      logic        group_is_full;
      logic        skipping;
      logic [1:0]  header_count;
      logic [7:0]  header_first;
      logic [15:0] length;
      logic [15:0] payload_count;
   } dec_state_type;

   // one result transaction
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [3:0]  command;
      logic [15:0] index;
      logic [15:0] length;
   } rsp_item_type;

   // state after one byte plus the results it caused
   typedef struct packed {
      dec_state_type                        state;
      rsp_item_type [MAX_RESULTS-1:0]       res;
      logic [1:0]                           count;
   } step_type;

endpackage

// ===== sv/cobs_leading_delim_deframer_top.sv =====
// ----------------------------------------------------------------------------
// cobs leading-delimiter deframer
// decodes a cobs byte stream where the zero delimiter opens each packet,
// parses the three-byte header and emits payload and status transactions
// ----------------------------------------------------------------------------
// path: an accepted byte is registered in the input stage, then decoded, and its
//   results are registered in the bundle; a busy bundle holds it in the input stage
// throughput: one byte per cycle while each byte yields at most one result and
//   rsp_stall is low; a byte that yields more results (up to 3) holds the input
//   stage until they drain, since the result port moves at most one transaction per cycle
// reset: synchronous, active high; clears decoder state, magic register and
//   both pipeline stages
// ----------------------------------------------------------------------------
module cobs_leading_delim_deframer_top (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data,
   // encoded byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // decoded result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [3:0]  rsp_command_code,
   output logic [15:0] rsp_payload_index,
   output logic [15:0] rsp_payload_length,
   output logic        rsp_last
);

   // append one result to the step bundle, fields taken from current state
   function automatic cobs_dfr_pkg::step_type emit(
      input cobs_dfr_pkg::step_type st,
      input cobs_dfr_pkg::kind_type kind,
      input logic [7:0]             data,
      input logic [15:0]            index
   );
      cobs_dfr_pkg::step_type       r;
      cobs_dfr_pkg::rsp_item_type   item;
      r          = st;
      item.kind  = kind;
      item.data  = data;
      item.index = index;
      item.command = (st.state.header_count >= 2'd1) ? st.state.header_first[3:0] : 4'd0;
      item.length  = (st.state.header_count >= 2'(cobs_dfr_pkg::HDR_BYTES))
                     ? st.state.length : 16'd0;
      if (st.count < 2'(cobs_dfr_pkg::MAX_RESULTS)) begin
         r.res[st.count] = item;
         r.count         = st.count + 2'd1;
      end
      return r;
   endfunction

   // one decoded byte goes to the header parser or out as payload
   function automatic cobs_dfr_pkg::step_type take_decoded(
      input cobs_dfr_pkg::step_type st,
      input logic [7:0]             b,
      input logic [3:0]             magic
   );
      cobs_dfr_pkg::step_type r;
      r = st;
      if (!r.state.skipping) begin
         if (r.state.header_count < 2'(cobs_dfr_pkg::HDR_BYTES)) begin
            case (r.state.header_count)
               2'd0: begin
                  r.state.header_first = b;
               end
               2'd1: begin
                  r.state.length[7:0] = b;
               end
               default: begin
                  r.state.length[15:8] = b;
               end
            endcase
            r.state.header_count = r.state.header_count + 2'd1;
            if (r.state.header_count == 2'(cobs_dfr_pkg::HDR_BYTES)) begin
               if (r.state.header_first[7:4] != magic) begin
                  r = emit(r, cobs_dfr_pkg::KIND_BAD_MAGIC, 8'd0, r.state.payload_count);
                  r.state.skipping = 1'b1;
               end else if (r.state.length == 16'd0) begin
                  r = emit(r, cobs_dfr_pkg::KIND_DONE, 8'd0, r.state.payload_count);
                  r.state.skipping = 1'b1;
               end
            end
         end else begin
            r = emit(r, cobs_dfr_pkg::KIND_PAYLOAD, b, r.state.payload_count);
            r.state.payload_count = r.state.payload_count + 16'd1;
            if (r.state.payload_count == r.state.length) begin
               r = emit(r, cobs_dfr_pkg::KIND_DONE, 8'd0, r.state.payload_count);
               r.state.skipping = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // state after a delimiter or after reset
   function automatic cobs_dfr_pkg::dec_state_type cleared();
      cobs_dfr_pkg::dec_state_type s;
      s.group_left    = 8'd0;
      s.group_is_full = 1'b1;
      s.skipping      = 1'b0;
      s.header_count  = 2'd0;
      s.header_first  = 8'd0;
      s.length        = 16'd0;
      s.payload_count = 16'd0;
      return s;
   endfunction

   // full per-byte update
   function automatic cobs_dfr_pkg::step_type decode_byte(
      input cobs_dfr_pkg::dec_state_type s,
      input logic [7:0]                  b,
      input logic [3:0]                  magic
   );
      cobs_dfr_pkg::step_type r;
      r       = '0;
      r.state = s;
      if (b == cobs_dfr_pkg::DELIM_BYTE) begin
         // delimiter in the middle of a packet reports truncation
         if (!s.skipping && (s.group_left != 8'd0 || s.header_count != 2'd0 ||
                             s.payload_count != 16'd0)) begin
            r = emit(r, cobs_dfr_pkg::KIND_TRUNCATED, 8'd0, s.payload_count);
         end
         r.state = cleared();
      end else if (!s.skipping) begin
         if (s.group_left == 8'd0) begin
            // code byte opens a group
            r.state.group_left    = b - 8'd1;
            r.state.group_is_full = (b == cobs_dfr_pkg::FULL_CODE);
         end else begin
            r.state.group_left = s.group_left - 8'd1;
            r = take_decoded(r, b, magic);
         end
         // inserted zero at the end of a short group
         if (!r.state.skipping && r.state.group_left == 8'd0 && !r.state.group_is_full) begin
            r.state.group_is_full = 1'b1;
            r = take_decoded(r, 8'd0, magic);
         end
      end
      return r;
   endfunction

   // configuration
   logic [3:0] magic_ff;

   // input stage
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // decoder state and result bundle
   cobs_dfr_pkg::dec_state_type                         state_ff;
   cobs_dfr_pkg::rsp_item_type [cobs_dfr_pkg::MAX_RESULTS-1:0] bundle_ff;
   logic [1:0]                                          bundle_count_ff;
   logic [1:0]                                          bundle_pos_ff;

   cobs_dfr_pkg::step_type     step_in;
   cobs_dfr_pkg::rsp_item_type cur_item;
   logic                       req_take;
   logic                       rsp_take;
   logic                       bundle_free;
   logic                       advance;

   assign step_in     = decode_byte(state_ff, in_byte_ff, magic_ff);

   // bundle register is free when empty or its final transaction leaves now
   assign rsp_valid   = (bundle_count_ff != 2'd0);
   assign rsp_take    = rsp_valid && !rsp_stall;
   assign bundle_free = (bundle_count_ff == 2'd0) || (bundle_count_ff == 2'd1 && rsp_take);
   assign advance     = in_valid_ff && bundle_free;

   // input stage holds one byte while the bundle drains
   assign req_stall   = in_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;

   // output mux over the bundle
   assign cur_item           = bundle_ff[bundle_pos_ff];
   assign rsp_out_kind       = cur_item.kind;
   assign rsp_out_byte       = cur_item.data;
   assign rsp_command_code   = cur_item.command;
   assign rsp_payload_index  = cur_item.index;
   assign rsp_payload_length = cur_item.length;
   assign rsp_last           = (bundle_count_ff == 2'd1);

   // magic nibble register
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= 4'd0;
      end else if (csr_write_enable) begin
         magic_ff <= csr_write_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // decoder state advances as each byte moves into the bundle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cleared();
      end else if (advance) begin
         state_ff <= step_in.state;
      end
   end

   // result bundle: load up to three transactions, drain one per cycle while rsp_stall is low
   always_ff @(posedge clock) begin
      if (reset) begin
         bundle_count_ff <= 2'd0;
         bundle_pos_ff   <= 2'd0;
      end else if (advance) begin
         bundle_count_ff <= step_in.count;
         bundle_pos_ff   <= 2'd0;
      end else if (rsp_take) begin
         bundle_count_ff <= bundle_count_ff - 2'd1;
         bundle_pos_ff   <= bundle_pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bundle_ff <= step_in.res;
      end
   end

   // bundle read pointer never runs past the three slots
   a_bundle_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, bundle_pos_ff} + {1'b0, bundle_count_ff}
                     <= 3'(cobs_dfr_pkg::MAX_RESULTS)))
      else $error("bundle pointer overrun");

   // status transactions always close out the byte that caused them
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind != cobs_dfr_pkg::KIND_PAYLOAD |-> rsp_last)
      else $error("status transaction not last");

   // payload position stays below the header length
   a_payload_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == cobs_dfr_pkg::KIND_PAYLOAD
      |-> rsp_payload_index < rsp_payload_length)
      else $error("payload index beyond length");

   // a byte held in the input stage is consumed once the bundle frees up
   a_input_drain: assert property (@(posedge clock) disable iff (reset)
      advance && !req_take |=> !in_valid_ff)
      else $error("input stage not released");

endmodule
